// ===== hw/rtl/zcsm_pkg.sv =====
// Shared types and constants for the zeroed current sense block.
// No dependencies; every other RTL file depends on this package.
`default_nettype none

package zcsm_pkg;

  // ADC code width
  localparam int CODE_BITS = 24;

  localparam int CAL_W      = 16;               // cal_attempts and counters
  localparam int SCALE_W    = 20;               // current_scale
  localparam int CFG_DATA_W = 20;               // widest register
  localparam int CFG_IDX_W  = 1;
  localparam int SUM_W      = CODE_BITS + CAL_W; // exact calibration sum
  localparam int CUR_W      = 29;               // Q8 current
  localparam int CUR_FRAC   = 16;               // scale shift
  localparam int DIFF_W     = CODE_BITS + 1;
  localparam int PROD_W     = DIFF_W + SCALE_W + 1;
  localparam int DIV_CNT_W  = $clog2(SUM_W + 1);

  localparam longint CUR_MAX = 64'sd268435455;
  localparam longint CUR_MIN = -64'sd268435456;

  localparam logic [CAL_W-1:0]   CAL_ATTEMPTS_RST  = CAL_W'(64);
  localparam logic [SCALE_W-1:0] CURRENT_SCALE_RST = SCALE_W'(100000);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_ATTEMPTS  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_SCALE = CFG_IDX_W'(1);

  typedef enum logic [0:0] {
    OP_MEASURE = 1'b0,
    OP_CAL     = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_CURRENT_OK  = 3'd0,
    ST_NO_SAMPLE   = 3'd1,
    ST_NOT_ZEROED  = 3'd2,
    ST_CAL_PENDING = 3'd3,
    ST_CAL_OK      = 3'd4,
    ST_CAL_FAILED  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_CAL_CHK,
    S_DIV,
    S_MUL,
    S_SAT,
    S_MED,
    S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic    capture;
    logic    cal_acc;
    logic    cal_fail;
    logic    cal_ok;
    logic    div_start;
    logic    load_diff;
    logic    mul;
    logic    sat;
    logic    med;
    logic    set_status;
    status_t status_code;
    logic    out_load;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    op_t  opcode;
    logic sample_ready;
    logic zero_valid;
    logic cal_end;
    logic cal_pass;
    logic div_done;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/zcsm_if.sv =====
// Valid/ready channel interfaces for sample items and result items.
// Depends on zcsm_pkg for field widths.
`default_nettype none

interface zcsm_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  opcode;
  logic                                  sample_ready;
  logic signed [zcsm_pkg::CODE_BITS-1:0] code;

  modport source (output valid, opcode, sample_ready, code, input ready);
  modport sink   (input valid, opcode, sample_ready, code, output ready);
endinterface

interface zcsm_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [2:0]                            status;
  logic signed [zcsm_pkg::CUR_W-1:0]     current_q8;
  logic signed [zcsm_pkg::CODE_BITS-1:0] zero_offset;

  modport source (output valid, status, current_q8, zero_offset, input ready);
  modport sink   (input valid, status, current_q8, zero_offset, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/zeroed_current_sense_median3.sv =====
// Top level of the zeroed current sense block with median-of-3 filter.
// Depends on zcsm_pkg, zcsm_if, zcsm_div, zcsm_dp and zcsm_ctrl.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    opcode, sample_ready, code
//   out_ch   out  valid/ready    status, current_q8, zero_offset
//   cfg_*    in   cfg_we only    cfg_index (0 cal_attempts, 1 current_scale),
//                                cfg_wdata
//
// One item at a time; in_ch.ready is high only while the controller idles.
// Measure steps: diff, multiply, saturate, median, output load.
// Calibration attempt: capture, accumulate, run-end check, output load; the last
// attempt of a passing run adds the restoring divider, one quotient bit per cycle
// over SUM_W (40) bits.
// Reset is synchronous, active low; no clearing pass is needed.
// The result sits in an output register; a new item is still accepted while
// it waits, and that item stalls only at its own output load.
`default_nettype none

module zeroed_current_sense_median3 (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  zcsm_in_if.sink                                in_ch,
  zcsm_out_if.source                             out_ch,
  input  wire logic [zcsm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [zcsm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire logic                              cfg_we
);
  import zcsm_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic      in_ready;
  logic      out_valid;

  // sequencer: handshakes and step order
  zcsm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // arithmetic, state and registers
  zcsm_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_opcode       (in_ch.opcode),
    .in_sample_ready (in_ch.sample_ready),
    .in_code         (in_ch.code),
    .cmd             (cmd),
    .stat            (stat),
    .out_status      (out_ch.status),
    .out_current_q8  (out_ch.current_q8),
    .out_zero_offset (out_ch.zero_offset)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

endmodule

`default_nettype wire

// ===== hw/rtl/zcsm_div.sv =====
// Restoring divider, one quotient bit per cycle, truncates toward zero.
// Signed calibration sum over unsigned good count; depends on zcsm_pkg.
`default_nettype none

module zcsm_div (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  start,
  input  wire logic signed [zcsm_pkg::SUM_W-1:0]     dividend,
  input  wire logic        [zcsm_pkg::CAL_W-1:0]     divisor,
  output logic                                       done,
  output logic signed      [zcsm_pkg::CODE_BITS-1:0] quotient
);
  import zcsm_pkg::*;

  logic [SUM_W-1:0]     quot_r, quot_nxt;
  logic [CAL_W-1:0]     rem_r, rem_nxt;
  logic [CAL_W-1:0]     dvs_r, dvs_nxt;
  logic                 neg_r, neg_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 done_r, done_nxt;
  logic [CAL_W:0]       trial;
  logic [SUM_W-1:0]     qsigned;

  always_comb begin
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quot_r[SUM_W-1]};
    if (start) begin
      neg_nxt  = dividend[SUM_W-1];
      quot_nxt = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = DIV_CNT_W'(SUM_W);
    end else if (cnt_r != '0) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt  = CAL_W'(trial - {1'b0, dvs_r});
        quot_nxt = {quot_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt  = trial[CAL_W-1:0];
        quot_nxt = {quot_r[SUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
    neg_r  <= neg_nxt;
  end

  assign qsigned  = neg_r ? (~quot_r + 1'b1) : quot_r;
  assign quotient = qsigned[CODE_BITS-1:0];
  assign done     = done_r;

endmodule

`default_nettype wire

// ===== hw/rtl/zcsm_dp.sv =====
// Datapath: config registers, item capture, calibration accumulators,
// scaling multiplier, saturation, median history. Uses zcsm_pkg, zcsm_div.
`default_nettype none

module zcsm_dp (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_we,
  input  wire logic        [zcsm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic        [zcsm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                                  in_opcode,
  input  wire logic                                  in_sample_ready,
  input  wire logic signed [zcsm_pkg::CODE_BITS-1:0] in_code,
  input  wire zcsm_pkg::ctrl_cmd_t                   cmd,
  output zcsm_pkg::dp_stat_t                         stat,
  output logic             [2:0]                     out_status,
  output logic signed      [zcsm_pkg::CUR_W-1:0]     out_current_q8,
  output logic signed      [zcsm_pkg::CODE_BITS-1:0] out_zero_offset
);
  import zcsm_pkg::*;

  localparam int SH_W  = PROD_W - CUR_FRAC;
  localparam int EXT_W = (SH_W > CUR_W) ? SH_W : CUR_W;
  localparam logic signed [EXT_W-1:0] CUR_MAX_EXT = EXT_W'(CUR_MAX);
  localparam logic signed [EXT_W-1:0] CUR_MIN_EXT = EXT_W'(CUR_MIN);

  function automatic logic signed [CUR_W-1:0] median3(
    input logic signed [CUR_W-1:0] a,
    input logic signed [CUR_W-1:0] b,
    input logic signed [CUR_W-1:0] c
  );
    logic signed [CUR_W-1:0] lo, hi, m;
    lo = (a < b) ? a : b;
    hi = (a > b) ? a : b;
    m  = (hi < c) ? hi : c;
    return (lo > m) ? lo : m;
  endfunction

  // configuration
  logic [CAL_W-1:0]   cal_attempts_r;
  logic [SCALE_W-1:0] current_scale_r;

  // captured item
  op_t                         item_op_r;
  logic                        item_rdy_r;
  logic signed [CODE_BITS-1:0] item_code_r;

  // persistent state
  logic signed [CODE_BITS-1:0] zero_code_r, zero_code_nxt;
  logic                        zero_valid_r, zero_valid_nxt;
  logic signed [CUR_W-1:0]     hist_newer_r, hist_older_r;
  logic signed [SUM_W-1:0]     sum_r, sum_nxt;
  logic [CAL_W-1:0]            attempt_r, attempt_nxt;
  logic [CAL_W-1:0]            good_r, good_nxt;

  // measure pipeline
  logic signed [DIFF_W-1:0]    diff_r;
  logic signed [PROD_W-1:0]    prod_r;
  logic signed [CUR_W-1:0]     raw_r;
  logic signed [SCALE_W:0]     scale_s;
  logic signed [SH_W-1:0]      sh_val;
  logic signed [EXT_W-1:0]     sh_ext;
  logic signed [EXT_W-1:0]     clamped;

  // result
  status_t                     res_status_r;
  logic signed [CUR_W-1:0]     res_cur_r;
  status_t                     out_status_r;
  logic signed [CUR_W-1:0]     out_cur_r;
  logic signed [CODE_BITS-1:0] out_zero_r;

  logic                        div_done;
  logic signed [CODE_BITS-1:0] div_quot;

  zcsm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (sum_r),
    .divisor  (good_r),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_attempts_r  <= CAL_ATTEMPTS_RST;
      current_scale_r <= CURRENT_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CAL_ATTEMPTS:  cal_attempts_r  <= cfg_wdata[CAL_W-1:0];
        CFG_CURRENT_SCALE: current_scale_r <= cfg_wdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // calibration bookkeeping
  always_comb begin
    sum_nxt        = sum_r;
    attempt_nxt    = attempt_r;
    good_nxt       = good_r;
    zero_code_nxt  = zero_code_r;
    zero_valid_nxt = zero_valid_r;
    if (cmd.cal_acc) begin
      if (item_rdy_r) begin
        sum_nxt  = sum_r + SUM_W'(item_code_r);
        good_nxt = good_r + 1'b1;
      end
      attempt_nxt = attempt_r + 1'b1;
    end
    if (cmd.cal_ok || cmd.cal_fail) begin
      sum_nxt     = '0;
      attempt_nxt = '0;
      good_nxt    = '0;
    end
    if (cmd.cal_ok) begin
      zero_code_nxt  = div_quot;
      zero_valid_nxt = 1'b1;
    end
    if (cmd.cal_fail) begin
      zero_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r        <= '0;
      attempt_r    <= '0;
      good_r       <= '0;
      zero_code_r  <= '0;
      zero_valid_r <= 1'b0;
      hist_newer_r <= '0;
      hist_older_r <= '0;
    end else begin
      sum_r        <= sum_nxt;
      attempt_r    <= attempt_nxt;
      good_r       <= good_nxt;
      zero_code_r  <= zero_code_nxt;
      zero_valid_r <= zero_valid_nxt;
      if (cmd.med) begin
        hist_older_r <= hist_newer_r;
        hist_newer_r <= raw_r;
      end
    end
  end

  // scaling: floor shift is an arithmetic right shift
  assign scale_s = {1'b0, current_scale_r};
  assign sh_val  = SH_W'(prod_r >>> CUR_FRAC);
  assign sh_ext  = EXT_W'(sh_val);
  always_comb begin
    if (sh_ext > CUR_MAX_EXT) begin
      clamped = CUR_MAX_EXT;
    end else if (sh_ext < CUR_MIN_EXT) begin
      clamped = CUR_MIN_EXT;
    end else begin
      clamped = sh_ext;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_op_r   <= op_t'(in_opcode);
      item_rdy_r  <= in_sample_ready;
      item_code_r <= in_code;
    end
    if (cmd.load_diff) begin
      diff_r <= DIFF_W'(item_code_r) - DIFF_W'(zero_code_r);
    end
    if (cmd.mul) begin
      prod_r <= diff_r * scale_s;
    end
    if (cmd.sat) begin
      raw_r <= clamped[CUR_W-1:0];
    end
    if (cmd.med) begin
      res_status_r <= ST_CURRENT_OK;
      res_cur_r    <= median3(hist_older_r, hist_newer_r, raw_r);
    end else if (cmd.set_status) begin
      res_status_r <= cmd.status_code;
      res_cur_r    <= '0;
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_cur_r    <= res_cur_r;
      out_zero_r   <= zero_code_r;
    end
  end

  always_comb begin
    stat.opcode       = item_op_r;
    stat.sample_ready = item_rdy_r;
    stat.zero_valid   = zero_valid_r;
    stat.cal_end      = (attempt_r >= cal_attempts_r);
    stat.cal_pass     = (good_r != '0) && (good_r >= (cal_attempts_r >> 1));
    stat.div_done     = div_done;
  end

  assign out_status      = out_status_r;
  assign out_current_q8  = out_cur_r;
  assign out_zero_offset = out_zero_r;

endmodule

`default_nettype wire

// ===== hw/rtl/zcsm_ctrl.sv =====
// Controller FSM: sequences one item through the datapath and owns the
// input ready and output valid. Depends on zcsm_pkg.
`default_nettype none

module zcsm_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire zcsm_pkg::dp_stat_t  stat,
  output zcsm_pkg::ctrl_cmd_t      cmd
);
  import zcsm_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.status_code = ST_CURRENT_OK;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.opcode == OP_CAL) begin
          cmd.cal_acc = 1'b1;
          state_nxt   = S_CAL_CHK;
        end else if (!stat.sample_ready) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_NO_SAMPLE;
          state_nxt       = S_DONE;
        end else if (!stat.zero_valid) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_NOT_ZEROED;
          state_nxt       = S_DONE;
        end else begin
          cmd.load_diff = 1'b1;
          state_nxt     = S_MUL;
        end
      end
      S_CAL_CHK: begin
        if (!stat.cal_end) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_CAL_PENDING;
          state_nxt       = S_DONE;
        end else if (stat.cal_pass) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          cmd.cal_fail    = 1'b1;
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_CAL_FAILED;
          state_nxt       = S_DONE;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.cal_ok      = 1'b1;
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_CAL_OK;
          state_nxt       = S_DONE;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_SAT;
      end
      S_SAT: begin
        cmd.sat   = 1'b1;
        state_nxt = S_MED;
      end
      S_MED: begin
        cmd.med   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign out_valid = out_valid_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result overwritten before transfer");

  a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    stat.div_done |-> (state_r == S_DIV))
    else $error("divider done outside divide state");

  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DECODE))
    else $error("accepted item not decoded");

  a_cal_ok_legal: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cal_ok |-> (stat.cal_end && stat.cal_pass))
    else $error("zero committed without a passing run");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for zeroed_current_sense_median3: directed table, then random phases.
// Depends on zcsm_pkg, zcsm_if and the block's RTL; needs no files or arguments.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import zcsm_pkg::*;

  // ---------------------------------------------------------------------------
  // Run shape
  // ---------------------------------------------------------------------------
  localparam int RAND_PHASES = 11;     // random phases after the directed table
  localparam int PHASE_ITEMS = 50;     // input transfers per random phase
  localparam int HOLD_CYCLES = 300;    // long output back-pressure stretch
  localparam int SETTLE      = 60;     // > slowest item (passing cal end)
  localparam int MAX_PRINTS  = 30;

  // One result as seen on out_ch
  typedef struct packed {
    status_t                     status;
    logic signed [CUR_W-1:0]     cur;
    logic signed [CODE_BITS-1:0] zero;
  } reading_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                   kind;
    op_t                         op;
    logic                        rdy;
    logic signed [CODE_BITS-1:0] code;
    bit                          typed;   // use want instead of the predictor
    reading_t                    want;
    logic [CFG_IDX_W-1:0]        idx;
    logic [CFG_DATA_W-1:0]       data;
  } stim_row_t;

  // ---------------------------------------------------------------------------
  // Clock, reset, DUT
  // ---------------------------------------------------------------------------
  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  zcsm_in_if  in_ch();
  zcsm_out_if out_ch();

  zeroed_current_sense_median3 dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_we    (cfg_we)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Bench state
  // ---------------------------------------------------------------------------
  reading_t  expected_readings[$];   // oldest first
  stim_row_t directed_rows[$];

  int mismatches    = 0;
  int readings_seen = 0;
  int items_sent    = 0;
  int reg_writes    = 0;
  int holds_asked   = 0;             // written by the sender only
  int holds_done    = 0;             // written by the receiver only
  bit calm          = 1'b0;          // no idling on either side
  int gap_pct       = 30;            // sender idle chance after a transfer

  // Predictor copy of the block's registers and state
  logic [CAL_W-1:0]            attempts_reg;
  logic [SCALE_W-1:0]          scale_reg;
  logic signed [CODE_BITS-1:0] offset_est;
  bit                          offset_ok;
  longint                      cur_prev1;     // newest unfiltered current
  longint                      cur_prev2;     // the one before
  longint                      cal_acc;       // exact running sum of ready codes
  logic [CAL_W-1:0]            tries;
  logic [CAL_W-1:0]            hits;
  int n_current = 0, n_cal_ok = 0, n_cal_fail = 0, n_refused = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic void reset_predictor();
    attempts_reg = CAL_ATTEMPTS_RST;
    scale_reg    = CURRENT_SCALE_RST;
    offset_est   = '0;
    offset_ok    = 1'b0;
    cur_prev1    = 0;
    cur_prev2    = 0;
    cal_acc      = 0;
    tries        = '0;
    hits         = '0;
  endfunction

  function automatic longint med3(longint a, longint b, longint c);
    longint lo, hi;
    lo = (a < b) ? a : b;
    hi = (a > b) ? a : b;
    if (hi < c) return hi;
    return (lo > c) ? lo : c;
  endfunction

  // Advances the predictor by one accepted item and returns its reading.
  function automatic reading_t predict_reading(op_t op, logic rdy,
                                               logic signed [CODE_BITS-1:0] code);
    reading_t r;
    longint   raw;
    r.cur = '0;
    if (op == OP_CAL) begin
      if (rdy) begin
        cal_acc += longint'(code);
        hits    += 1'b1;
      end
      tries += 1'b1;
      if (tries >= attempts_reg) begin
        // hits == 0 is a failure, so the average never divides by zero
        if (hits != 0 && hits >= (attempts_reg >> 1)) begin
          offset_est = CODE_BITS'(cal_acc / longint'(hits));   // truncates toward zero
          offset_ok  = 1'b1;
          r.status   = ST_CAL_OK;
          n_cal_ok++;
        end else begin
          offset_ok = 1'b0;                                    // old offset is kept
          r.status  = ST_CAL_FAILED;
          n_cal_fail++;
        end
        cal_acc = 0;
        tries   = '0;
        hits    = '0;
      end else begin
        r.status = ST_CAL_PENDING;
      end
    end else if (!rdy) begin
      r.status = ST_NO_SAMPLE;
      n_refused++;
    end else if (!offset_ok) begin
      r.status = ST_NOT_ZEROED;
      n_refused++;
    end else begin
      // floor((code - zero) * scale / 2^16), clamped to the Q8 range
      raw = ((longint'(code) - longint'(offset_est)) * longint'(scale_reg)) >>> CUR_FRAC;
      if (raw > CUR_MAX) raw = CUR_MAX;
      if (raw < CUR_MIN) raw = CUR_MIN;
      r.cur     = CUR_W'(med3(cur_prev2, cur_prev1, raw));
      cur_prev2 = cur_prev1;
      cur_prev1 = raw;
      r.status  = ST_CURRENT_OK;
      n_current++;
    end
    r.zero = offset_est;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, longint got, longint want);
    if (mismatches < MAX_PRINTS)
      $display("[%0t] MISMATCH %s on reading %0d: got %0d, want %0d",
               $realtime, what, readings_seen, got, want);
    mismatches++;
  endtask

  task automatic check_reading();
    reading_t want;
    if (expected_readings.size() == 0) begin
      report_mismatch("unexpected result, status", longint'(out_ch.status), -1);
      return;
    end
    want = expected_readings.pop_front();
    if (out_ch.status !== want.status)
      report_mismatch("status", longint'(out_ch.status), longint'(want.status));
    if (out_ch.current_q8 !== want.cur)
      report_mismatch("current_q8", longint'(out_ch.current_q8), longint'(want.cur));
    if (out_ch.zero_offset !== want.zero)
      report_mismatch("zero_offset", longint'(out_ch.zero_offset), longint'(want.zero));
    readings_seen++;
  endtask

  // Receiver: samples the pre-edge handshake, then drives ready for the next cycle.
  // Ready comes in random runs; a requested hold keeps it low for HOLD_CYCLES.
  initial begin : receiver
    int  run_left;
    bit  stalling;
    run_left     = 0;
    stalling     = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        check_reading();
      if (rst_n !== 1'b1) begin
        out_ch.ready <= 1'b0;
      end else if (holds_done < holds_asked) begin
        // long back-pressure: block fills up and stalls in_ch
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
        run_left = 0;
      end else if (calm) begin
        out_ch.ready <= 1'b1;
      end else begin
        if (run_left == 0) begin
          stalling = ($urandom_range(2) == 0);
          // ready runs are sometimes long, giving stretches without idling
          run_left = stalling ? $urandom_range(16, 1)
                              : $urandom_range(($urandom_range(3) == 0) ? 64 : 16, 1);
        end
        out_ch.ready <= !stalling;
        run_left--;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offers one item, waits for its transfer, records the expected reading.
  // Unless a random gap drops it, valid stays high on return so a following item goes back to back.
  task automatic send_sample(op_t op, logic rdy, logic signed [CODE_BITS-1:0] code,
                             bit typed, reading_t want);
    reading_t pred;
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= op;
    in_ch.sample_ready <= rdy;
    in_ch.code         <= code;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    pred = predict_reading(op, rdy, code);
    expected_readings.push_back(typed ? want : pred);
    items_sent++;
    if (!calm && $urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(16, 1)) @(posedge clk);
    end
  endtask

  // Sender pause: nothing offered until every reading is back and the block idles.
  task automatic wait_all_readings();
    in_ch.valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Only called while the block is idle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_CAL_ATTEMPTS) attempts_reg = data[CAL_W-1:0];
    else                         scale_reg    = data[SCALE_W-1:0];
    reg_writes++;
  endtask

  // Table builders
  task automatic plan_item(op_t op, logic rdy, logic signed [CODE_BITS-1:0] code);
    stim_row_t row;
    row.kind  = ROW_ITEM;
    row.op    = op;
    row.rdy   = rdy;
    row.code  = code;
    row.typed = 1'b0;
    row.want  = '0;
    row.idx   = '0;
    row.data  = '0;
    directed_rows.push_back(row);
  endtask

  // Typed rows: current is always 0 there.
  task automatic plan_typed(op_t op, logic rdy, logic signed [CODE_BITS-1:0] code,
                            status_t st, logic signed [CODE_BITS-1:0] zero);
    stim_row_t row;
    row.kind        = ROW_ITEM;
    row.op          = op;
    row.rdy         = rdy;
    row.code        = code;
    row.typed       = 1'b1;
    row.want.status = st;
    row.want.cur    = '0;
    row.want.zero   = zero;
    row.idx         = '0;
    row.data        = '0;
    directed_rows.push_back(row);
  endtask

  task automatic plan_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    stim_row_t row;
    row.kind  = ROW_CFG;
    row.op    = OP_MEASURE;
    row.rdy   = 1'b0;
    row.code  = '0;
    row.typed = 1'b0;
    row.want  = '0;
    row.idx   = idx;
    row.data  = data;
    directed_rows.push_back(row);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : sender
    int                          target;
    int                          run_len;
    int                          good_pct;
    int                          pick;
    logic signed [CODE_BITS-1:0] center;
    logic signed [CODE_BITS-1:0] code;
    reading_t                    none;
    bit                          paused;

    none   = '0;
    paused = 1'b0;
    // every input known from time zero
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.opcode       = 1'b0;
    in_ch.sample_ready = 1'b0;
    in_ch.code         = '0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    reset_predictor();
    @(posedge clk);

    // --- directed table -----------------------------------------------------
    // out of reset: not zeroed, then no sample, both at the code extremes
    plan_typed(OP_MEASURE, 1'b1, 24'sh7FFFFF,  ST_NOT_ZEROED,  '0);
    plan_typed(OP_MEASURE, 1'b0, -24'sh800000, ST_NO_SAMPLE,   '0);
    plan_typed(OP_CAL,     1'b1, -24'sh800000, ST_CAL_PENDING, '0);
    // lowering cal_attempts below the count ends the run on the next attempt
    plan_reg(CFG_CAL_ATTEMPTS, 1);
    plan_item(OP_CAL, 1'b0, 0);
    // full scale, largest positive difference and median ordering
    plan_reg(CFG_CURRENT_SCALE, 20'hFFFFF);
    plan_item(OP_MEASURE, 1'b1, 24'sh7FFFFF);
    plan_item(OP_MEASURE, 1'b1, -24'sh800000);
    plan_item(OP_MEASURE, 1'b1, 0);
    plan_item(OP_MEASURE, 1'b1, 1234567);
    // negative average truncates toward zero; a measure mid-run leaves the sum alone
    plan_reg(CFG_CAL_ATTEMPTS, 2);
    plan_typed(OP_CAL, 1'b1, -3, ST_CAL_PENDING, -24'sh800000);
    plan_item(OP_MEASURE, 1'b1, 100);
    plan_typed(OP_CAL, 1'b1, -2, ST_CAL_OK, -2);
    plan_item(OP_MEASURE, 1'b1, -2);
    // run with no good sample fails and keeps the old offset
    plan_reg(CFG_CAL_ATTEMPTS, 1);
    plan_typed(OP_CAL,     1'b0, 5, ST_CAL_FAILED, -2);
    plan_typed(OP_MEASURE, 1'b1, 7, ST_NOT_ZEROED, -2);
    // exactly half the attempts good is enough
    plan_reg(CFG_CAL_ATTEMPTS, 4);
    plan_item(OP_CAL, 1'b1, 24'sh7FFFFF);
    plan_item(OP_CAL, 1'b0, 0);
    plan_item(OP_CAL, 1'b0, -1);
    plan_item(OP_CAL, 1'b1, 24'sh7FFFFF);
    plan_item(OP_MEASURE, 1'b1, -24'sh800000);
    // zero scale: new currents are 0, the median still sees history
    plan_reg(CFG_CURRENT_SCALE, 0);
    plan_item(OP_MEASURE, 1'b1, 12345);
    plan_item(OP_MEASURE, 1'b1, -1);
    // cal_attempts of 0 ends every run on its first attempt
    plan_reg(CFG_CAL_ATTEMPTS, 0);
    plan_item(OP_CAL, 1'b1, 4660);
    plan_item(OP_CAL, 1'b0, 0);
    plan_reg(CFG_CAL_ATTEMPTS, 20'hFFFF);
    plan_item(OP_CAL, 1'b1, 1);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        wait_all_readings();
        write_reg(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        send_sample(directed_rows[i].op, directed_rows[i].rdy, directed_rows[i].code,
                    directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // --- random phases ------------------------------------------------------
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      wait_all_readings();
      case (phase)
        0: begin
          write_reg(CFG_CAL_ATTEMPTS, 1);
          write_reg(CFG_CURRENT_SCALE, 20'hFFFFF);
        end
        1: begin
          write_reg(CFG_CAL_ATTEMPTS, 2);
          write_reg(CFG_CURRENT_SCALE, 1);
        end
        2: begin
          // runs never complete here; the next phase cuts them short
          write_reg(CFG_CAL_ATTEMPTS, 20'hFFFF);
          write_reg(CFG_CURRENT_SCALE, CURRENT_SCALE_RST);
        end
        default: begin
          write_reg(CFG_CAL_ATTEMPTS, CFG_DATA_W'($urandom_range(8, 1)));
          write_reg(CFG_CURRENT_SCALE,
                    CFG_DATA_W'(($urandom_range(1) == 0) ? $urandom_range(4095, 1)
                                                         : $urandom_range(20'hFFFFF, 1)));
        end
      endcase
      gap_pct = (phase % 3 == 0) ? 0 : 30;
      calm    = (phase == RAND_PHASES - 1);
      if (phase == 3) holds_asked++;    // sender keeps offering through the hold

      target = items_sent + PHASE_ITEMS;
      center = CODE_BITS'($urandom());
      while (items_sent < target) begin
        // sender pause halfway through one phase
        if (phase == 6 && !paused && items_sent >= target - PHASE_ITEMS / 2) begin
          wait_all_readings();
          paused = 1'b1;
        end
        pick = $urandom_range(99);
        if (pick < 22) begin
          // well-formed calibration run around a fresh center
          run_len  = (attempts_reg == 0 || attempts_reg > 8) ? 3 : int'(attempts_reg);
          good_pct = ($urandom_range(2) == 0) ? 40 : 95;
          center   = ($urandom_range(3) == 0) ? CODE_BITS'($urandom())
                                              : CODE_BITS'($urandom_range(4000) - 2000);
          for (int j = 0; j < run_len; j++) begin
            code = center + CODE_BITS'($urandom_range(200) - 100);
            send_sample(OP_CAL, $urandom_range(99) < good_pct, code, 1'b0, none);
          end
        end else if (pick < 27) begin
          // stray attempt breaks run alignment
          send_sample(OP_CAL, 1'($urandom_range(1)), CODE_BITS'($urandom()), 1'b0, none);
        end else begin
          code = ($urandom_range(1) == 0) ? CODE_BITS'($urandom())
                                          : center + CODE_BITS'($urandom_range(20000) - 10000);
          send_sample(OP_MEASURE, $urandom_range(15) != 0, code, 1'b0, none);
        end
      end
    end

    // --- wind down ----------------------------------------------------------
    wait_all_readings();
    repeat (SETTLE) @(posedge clk);

    $display("run covered %0d items and %0d readings over %0d register writes",
             items_sent, readings_seen, reg_writes);
    $display("  %0d currents, %0d calibrations passed, %0d failed, %0d refused measures",
             n_current, n_cal_ok, n_cal_fail, n_refused);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run
  initial begin : watchdog
    #2000000;
    $display("[%0t] timeout with %0d readings outstanding", $realtime,
             expected_readings.size());
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire
